@@ design/spsort_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Spiral sorter package
// Key layout and cell control word shared by the insertion chain and the top
// level, and the spiral key function that the top level uses.
// ----------------------------------------------------------------------------
package spsort_pkg;

  // Grid coordinate width and the coordinate view used for key arithmetic.
  localparam int GridW = 16;
  // Key: ring in the high bits, then the edge code, then the position.
  localparam int EdgeW = 2;
  localparam int KeyW  = GridW + EdgeW + GridW;

  typedef logic [GridW-1:0] grid_t;
  typedef logic [KeyW-1:0]  key_t;

  typedef enum logic [EdgeW-1:0] {
    EDGE_TOP    = 2'd0,
    EDGE_RIGHT  = 2'd1,
    EDGE_BOTTOM = 2'd2,
    EDGE_LEFT   = 2'd3
  } edge_t;

  // Control broadcast to every cell of the chain at once.
  typedef struct packed {
    logic ins;     // insert the broadcast point
    logic shift;   // move every entry one place toward cell zero
    key_t key;     // key of the broadcast point
  } cell_ctl_t;

  // Ring, edge and position for a point inside an n by n grid.
  function automatic key_t spiral_key(grid_t x, grid_t y, grid_t n);
    grid_t top;
    grid_t right;
    grid_t bottom;
    grid_t left;
    grid_t ring;
    grid_t pos;
    edge_t edge_code;
    top    = y;
    right  = n - grid_t'(1) - x;
    bottom = n - grid_t'(1) - y;
    left   = x;
    ring   = top;
    if (right < ring) ring = right;
    if (bottom < ring) ring = bottom;
    if (left < ring) ring = left;
    priority if (top == ring) begin
      edge_code = EDGE_TOP;
      pos = x;
    end else if (right == ring) begin
      edge_code = EDGE_RIGHT;
      pos = y;
    end else if (bottom == ring) begin
      edge_code = EDGE_BOTTOM;
      pos = right;
    end else begin
      edge_code = EDGE_LEFT;
      pos = bottom;
    end
    return {ring, edge_code, pos};
  endfunction

endpackage

@@ design/spsort_cell.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Spiral sorter cell
// One place of the sorted insertion chain: holds a point and its key, and
// trades it with its neighbors on insertion or drain.
// ----------------------------------------------------------------------------
module spsort_cell #(
  parameter int CW = 16
) (
  input  logic                   clk,
  input  spsort_pkg::cell_ctl_t  ctl,
  input  logic [CW-1:0]          new_x,
  input  logic [CW-1:0]          new_y,
  input  logic                   occ,
  input  logic                   prev_greater,
  input  logic [CW-1:0]          prev_x,
  input  logic [CW-1:0]          prev_y,
  input  spsort_pkg::key_t       prev_key,
  input  logic [CW-1:0]          next_x,
  input  logic [CW-1:0]          next_y,
  input  spsort_pkg::key_t       next_key,
  output logic [CW-1:0]          x,
  output logic [CW-1:0]          y,
  output spsort_pkg::key_t       key,
  output logic                   greater
);

  // An empty place sorts after everything, so the new point lands after
  // every stored point with an equal key.
  assign greater = !occ || (key > ctl.key);

  always_ff @(posedge clk) begin
    if (ctl.shift) begin
      x   <= next_x;
      y   <= next_y;
      key <= next_key;
    end else if (ctl.ins && greater) begin
      if (prev_greater) begin
        x   <= prev_x;
        y   <= prev_y;
        key <= prev_key;
      end else begin
        x   <= new_x;
        y   <= new_y;
        key <= ctl.key;
      end
    end
  end

endmodule

@@ design/spiral_order_point_sorter.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Spiral order point sorter
// Collects grid points and sends them back in clockwise spiral order.
// ----------------------------------------------------------------------------
//
//   Channel   Direction  Handshake                 Contents
//   s_axis    in         s_axis_tvalid/tready      point_x, point_y, last_point
//   m_axis    out        m_axis_tvalid/tready      sorted_x, sorted_y, flags
//   cfg       in         cfg_we (no stall)         grid_size
//
// While loading, one word is taken every cycle that s_axis_tvalid is high,
// except where the input is held off as below. A word first passes a key
// register, where the spiral key and the grid check are formed, and is then
// inserted into the chain of cells. The word that carries tlast holds off the
// input while it sits in the key register; it enters the chain from there.
// After that the chain drains one point per cycle into the output register
// while m_axis_tready stays high; the input is held off until the last point
// has left the chain.
// An output stall freezes the drain; it never loses or repeats a word.
// Reset is synchronous: it empties the chain, clears the drop flag and sets
// the grid size to one.
// ----------------------------------------------------------------------------
module spiral_order_point_sorter #(
  parameter int MAX_POINTS = 64,
  parameter int COORD_BITS = 16
) (
  input  logic        clk,
  input  logic        rst,
  // Configuration: grid_size.
  input  logic        cfg_we,
  input  logic [15:0] cfg_data,
  // Input words.
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,   // [15:0] point_x, [31:16] point_y
  input  logic        s_axis_tlast,   // last_point
  // Result words.
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,   // [15:0] sorted_x, [31:16] sorted_y
  output logic        m_axis_tlast,   // last_result
  output logic        m_axis_tuser    // points_dropped
);

  localparam int CntW = $clog2(MAX_POINTS + 1);

  // Configured side length of the grid.
  spsort_pkg::grid_t grid_size;

  // Key register between the input and the chain.
  logic                  stg_valid;
  logic                  stg_last;
  logic                  stg_ok;
  logic [COORD_BITS-1:0] stg_x;
  logic [COORD_BITS-1:0] stg_y;
  spsort_pkg::key_t      stg_key;

  // Chain bookkeeping: count of stored points, drop flags and drain state.
  logic [CntW-1:0] count;
  logic            drop;
  logic            drop_rep;
  logic            draining;

  // Output register.
  logic [COORD_BITS-1:0] out_x;
  logic [COORD_BITS-1:0] out_y;

  logic [COORD_BITS-1:0] in_x;
  logic [COORD_BITS-1:0] in_y;
  spsort_pkg::grid_t     in_x16;
  spsort_pkg::grid_t     in_y16;
  logic                  in_fire;
  logic                  ins;
  logic                  drop_now;
  logic                  out_load;
  logic [CntW-1:0]       count_after;
  spsort_pkg::cell_ctl_t ctl;

  // Chain wiring; each entry is read by its own cell and its neighbors, and entry zero also by the output register.
  logic [COORD_BITS-1:0] cx  [MAX_POINTS];
  logic [COORD_BITS-1:0] cy  [MAX_POINTS];
  spsort_pkg::key_t      ck  [MAX_POINTS];
  logic [MAX_POINTS-1:0] cgt;

  // Coordinates are taken in their low COORD_BITS bits.
  assign in_x   = COORD_BITS'(s_axis_tdata[15:0]);
  assign in_y   = COORD_BITS'(s_axis_tdata[31:16]);
  assign in_x16 = spsort_pkg::GridW'(in_x);
  assign in_y16 = spsort_pkg::GridW'(in_y);

  // The input stays closed while the chain drains and while the word that
  // ends a set is on its way into the chain.
  assign s_axis_tready = !draining && !(stg_valid && stg_last);
  assign in_fire       = s_axis_tvalid && s_axis_tready;

  // A point enters the chain only if it lies on the grid and a place is free.
  assign ins      = stg_valid && stg_ok && (count < CntW'(MAX_POINTS));
  assign drop_now = stg_valid && !ins;
  assign count_after = count + CntW'(ins);

  // The head of the chain moves into the output register when it is free.
  assign out_load = draining && (!m_axis_tvalid || m_axis_tready);

  assign ctl.ins   = ins;
  assign ctl.shift = out_load;
  assign ctl.key   = stg_key;

  always_ff @(posedge clk) begin
    if (rst) begin
      grid_size <= spsort_pkg::grid_t'(1);
    end else if (cfg_we) begin
      grid_size <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      stg_valid <= 1'b0;
    end else begin
      stg_valid <= in_fire;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      stg_last <= s_axis_tlast;
      stg_ok   <= (in_x16 < grid_size) && (in_y16 < grid_size);
      stg_x    <= in_x;
      stg_y    <= in_y;
      stg_key  <= spsort_pkg::spiral_key(in_x16, in_y16, grid_size);
    end
  end

  // Count, drop flags and drain control.
  always_ff @(posedge clk) begin
    if (rst) begin
      count    <= '0;
      drop     <= 1'b0;
      drop_rep <= 1'b0;
      draining <= 1'b0;
    end else begin
      if (out_load) begin
        count <= count - CntW'(1);
        if (count == CntW'(1)) begin
          draining <= 1'b0;
        end
      end else begin
        count <= count_after;
      end
      if (stg_valid && stg_last) begin
        // The set is closed: report its drop flag with the run, if any.
        drop     <= 1'b0;
        drop_rep <= drop || drop_now;
        draining <= (count_after != '0);
      end else if (drop_now) begin
        drop <= 1'b1;
      end
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (out_load) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_x        <= cx[0];
      out_y        <= cy[0];
      m_axis_tlast <= (count == CntW'(1));
      m_axis_tuser <= drop_rep;
    end
  end

  assign m_axis_tdata = {16'(out_y), 16'(out_x)};

  // The chain of cells, cell zero holding the smallest key.
  for (genvar i = 0; i < MAX_POINTS; i++) begin : g_cell
    logic                  prev_gt;
    logic [COORD_BITS-1:0] prev_x;
    logic [COORD_BITS-1:0] prev_y;
    spsort_pkg::key_t      prev_key;
    logic [COORD_BITS-1:0] next_x;
    logic [COORD_BITS-1:0] next_y;
    spsort_pkg::key_t      next_key;

    if (i == 0) begin : g_head
      assign prev_gt  = 1'b0;
      assign prev_x   = '0;
      assign prev_y   = '0;
      assign prev_key = '0;
    end else begin : g_body
      assign prev_gt  = cgt[i-1];
      assign prev_x   = cx[i-1];
      assign prev_y   = cy[i-1];
      assign prev_key = ck[i-1];
    end

    if (i == MAX_POINTS - 1) begin : g_tail
      assign next_x   = '0;
      assign next_y   = '0;
      assign next_key = '0;
    end else begin : g_inner
      assign next_x   = cx[i+1];
      assign next_y   = cy[i+1];
      assign next_key = ck[i+1];
    end

    spsort_cell #(
      .CW (COORD_BITS)
    ) u_cell (
      .clk          (clk),
      .ctl          (ctl),
      .new_x        (stg_x),
      .new_y        (stg_y),
      .occ          (CntW'(i) < count),
      .prev_greater (prev_gt),
      .prev_x       (prev_x),
      .prev_y       (prev_y),
      .prev_key     (prev_key),
      .next_x       (next_x),
      .next_y       (next_y),
      .next_key     (next_key),
      .x            (cx[i]),
      .y            (cy[i]),
      .key          (ck[i]),
      .greater      (cgt[i])
    );
  end

`ifndef SYNTHESIS
  // The chain never holds more points than it has cells.
  assert property (@(posedge clk) disable iff (rst) count <= CntW'(MAX_POINTS))
    else $error("point count exceeds chain length");

  // A drain always has at least one point left to send.
  assert property (@(posedge clk) disable iff (rst) draining |-> count != '0)
    else $error("drain active with an empty chain");

  // Insertion and drain never act on the chain in the same cycle.
  assert property (@(posedge clk) disable iff (rst) !(ins && out_load))
    else $error("insert during drain");

  // Every point moved out of the chain lowers the count by one.
  assert property (@(posedge clk) disable iff (rst)
    out_load |=> count == $past(count) - CntW'(1))
    else $error("drain did not decrement the count");
`endif

endmodule
